>>> rtl/hbpwm_pkg.sv
// Package with command codes, widths and word types for the H-bridge PWM driver.
`timescale 1ns / 1ps

package hbpwm_pkg;

    localparam int KIND_W  = 3;
    localparam int SPEED_W = 16;
    localparam int DUTY_W  = 10;
    localparam int NUM_CH  = 4;
    localparam int REG_IDX_W  = 1;
    localparam int REG_DATA_W = 10;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_MAX_SPEED    = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_REVERSE_MASK = 1'd1;

    // Register reset values
    localparam logic [DUTY_W-1:0] MAX_SPEED_RST    = 10'd100;
    localparam logic [NUM_CH-1:0] REVERSE_MASK_RST = 4'b0110;

    // Command codes
    localparam logic [KIND_W-1:0] KIND_SET_WHEELS = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PWM_TICK   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_COAST      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BRAKE      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LOCK       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_UNLOCK     = 3'd5;

    localparam logic [NUM_CH-1:0] ALL_CH = '1;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic signed [SPEED_W-1:0] speed_left_front;
        logic signed [SPEED_W-1:0] speed_left_rear;
        logic signed [SPEED_W-1:0] speed_right_rear;
        logic signed [SPEED_W-1:0] speed_right_front;
    } cmd_t;

    // Clamp a signed speed to +/- lim
    function automatic logic signed [DUTY_W:0] sat_speed(
        input logic signed [SPEED_W-1:0] speed,
        input logic [DUTY_W-1:0]         lim
    );
        logic signed [SPEED_W:0] s_ext;
        logic signed [SPEED_W:0] lim_ext;
        logic signed [SPEED_W:0] res;
        s_ext   = {speed[SPEED_W-1], speed};
        lim_ext = {{(SPEED_W-DUTY_W+1){1'b0}}, lim};
        if (s_ext > lim_ext)
            res = lim_ext;
        else if (s_ext < -lim_ext)
            res = -lim_ext;
        else
            res = s_ext;
        return res[DUTY_W:0];
    endfunction

endpackage

>>> rtl/hbpwm_cmd_if.sv
// Channel interfaces for command words and pin-state words.
`timescale 1ns / 1ps

interface hbpwm_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic signed [15:0] speed_left_front;
    logic signed [15:0] speed_left_rear;
    logic signed [15:0] speed_right_rear;
    logic signed [15:0] speed_right_front;

    modport source (
        output valid, kind, speed_left_front, speed_left_rear,
               speed_right_rear, speed_right_front,
        input  ready
    );
    modport sink (
        input  valid, kind, speed_left_front, speed_left_rear,
               speed_right_rear, speed_right_front,
        output ready
    );
endinterface

interface hbpwm_pin_if;
    logic       valid;
    logic       ready;
    logic [3:0] first_inputs;
    logic [3:0] second_inputs;
    logic [3:0] pwm_pins;
    logic       standby;
    logic       is_locked;

    modport source (
        output valid, first_inputs, second_inputs, pwm_pins, standby, is_locked,
        input  ready
    );
    modport sink (
        input  valid, first_inputs, second_inputs, pwm_pins, standby, is_locked,
        output ready
    );
endinterface

>>> rtl/four_channel_hbridge_pwm_driver_core.sv
// Top level of the four-channel H-bridge PWM driver with its register file.
`timescale 1ns / 1ps

// Takes one command word per clock and returns one pin-state word per command;
// each is registered in the input register, then in the execute stage whose
// state registers form the result word. Full rate holds as long as results
// are taken; the input register keeps accepting while a result waits, and
// cmd.ready drops only when both stages hold a word. Registers max_speed
// (index 0) and reverse_mask (index 1) are written through cfg_we, cfg_index
// and cfg_data; the user must do so only while no command is in flight, as
// the block does not enforce it. The driver resets locked; unlock enables it.
module four_channel_hbridge_pwm_driver_core
    import hbpwm_pkg::*;
#(
    parameter int PWM_STEPS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [REG_DATA_W-1:0] cfg_data,
    hbpwm_cmd_if.sink             cmd,
    hbpwm_pin_if.source           pins
);

    logic [DUTY_W-1:0] max_speed_reg;
    logic [NUM_CH-1:0] reverse_mask_reg;
    logic              stage_vld;
    cmd_t              stage_word;
    logic              stage_take;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg    <= MAX_SPEED_RST;
            reverse_mask_reg <= REVERSE_MASK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_SPEED:    max_speed_reg    <= cfg_data[DUTY_W-1:0];
                REG_REVERSE_MASK: reverse_mask_reg <= cfg_data[NUM_CH-1:0];
                default:          max_speed_reg    <= max_speed_reg;
            endcase
        end
    end

    hbpwm_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .vld   (stage_vld),
        .word  (stage_word),
        .take  (stage_take)
    );

    hbpwm_exec #(
        .PWM_STEPS (PWM_STEPS)
    ) u_exec (
        .clk          (clk),
        .rst_n        (rst_n),
        .vld          (stage_vld),
        .word         (stage_word),
        .take         (stage_take),
        .max_speed    (max_speed_reg),
        .reverse_mask (reverse_mask_reg),
        .pins         (pins)
    );

endmodule

>>> rtl/hbpwm_in_stage.sv
// Input register stage that holds one command word ahead of the execute stage.
`timescale 1ns / 1ps

module hbpwm_in_stage
    import hbpwm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    hbpwm_cmd_if.sink cmd,
    output logic      vld,
    output cmd_t      word,
    input  logic      take
);

    logic vld_reg;
    logic vld_next;
    cmd_t word_reg;
    logic load;

    // Load a new word when the stage is empty or its word moves on
    assign cmd.ready = !vld_reg || take;
    assign load      = cmd.valid && cmd.ready;

    always_comb
    begin
        if (load)
            vld_next = 1'b1;
        else if (take)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg.kind              <= cmd.kind;
            word_reg.speed_left_front  <= cmd.speed_left_front;
            word_reg.speed_left_rear   <= cmd.speed_left_rear;
            word_reg.speed_right_rear  <= cmd.speed_right_rear;
            word_reg.speed_right_front <= cmd.speed_right_front;
        end
    end

    assign vld  = vld_reg;
    assign word = word_reg;

endmodule

>>> rtl/hbpwm_exec.sv
// Execute stage: applies one command to the driver state and presents the pin word.
`timescale 1ns / 1ps

module hbpwm_exec
    import hbpwm_pkg::*;
#(
    parameter int PWM_STEPS = 10
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic              vld,
    input  cmd_t              word,
    output logic              take,
    input  logic [DUTY_W-1:0] max_speed,
    input  logic [NUM_CH-1:0] reverse_mask,
    hbpwm_pin_if.source       pins
);

    localparam int PH_W  = (PWM_STEPS > 2) ? $clog2(PWM_STEPS) : 1;
    localparam int THR_W = $clog2(PWM_STEPS * (PWM_STEPS - 1) + 1);
    localparam int CMP_W = (THR_W > DUTY_W) ? THR_W : DUTY_W;
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(PWM_STEPS - 1);

    logic              out_vld_reg;
    logic              locked_reg, locked_next;
    logic [NUM_CH-1:0] first_reg, first_next;
    logic [NUM_CH-1:0] second_reg, second_next;
    logic [NUM_CH-1:0] pwm_reg, pwm_next;
    logic              standby_reg, standby_next;
    logic [DUTY_W-1:0] duty_reg [NUM_CH];
    logic [DUTY_W-1:0] duty_next [NUM_CH];
    logic [PH_W-1:0]   phase_reg, phase_next;

    logic signed [SPEED_W-1:0] speed [NUM_CH];
    logic signed [DUTY_W:0]    sat [NUM_CH];
    logic [DUTY_W:0]           mag [NUM_CH];
    logic [NUM_CH-1:0]         fwd;
    logic [NUM_CH-1:0]         rev;
    logic [NUM_CH-1:0]         pwm_cmp;
    logic [CMP_W-1:0]          thr;
    logic                      apply;

    // Advance when the result slot is free or being drained
    assign take  = !out_vld_reg || pins.ready;
    assign apply = vld && take;

    assign speed[0] = word.speed_left_front;
    assign speed[1] = word.speed_left_rear;
    assign speed[2] = word.speed_right_rear;
    assign speed[3] = word.speed_right_front;

    // Saturate speeds and derive direction per channel
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            sat[c] = sat_speed(speed[c], max_speed);
            mag[c] = sat[c][DUTY_W] ? (DUTY_W+1)'(-sat[c]) : sat[c];
            fwd[c] = (sat[c] != '0) && (sat[c][DUTY_W] == reverse_mask[c]);
            rev[c] = (sat[c] != '0) && (sat[c][DUTY_W] != reverse_mask[c]);
        end
    end

    // Compare duties against the current phase threshold
    assign thr = CMP_W'(phase_reg) * CMP_W'(PWM_STEPS);

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
            pwm_cmp[c] = CMP_W'(duty_reg[c]) > thr;
    end

    // Command decode
    always_comb
    begin
        locked_next  = locked_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        pwm_next     = pwm_reg;
        standby_next = standby_reg;
        phase_next   = phase_reg;
        for (int c = 0; c < NUM_CH; c++)
            duty_next[c] = duty_reg[c];

        case (word.kind)
            KIND_SET_WHEELS:
            begin
                if (!locked_reg)
                begin
                    standby_next = 1'b1;
                    first_next   = fwd;
                    second_next  = rev;
                    for (int c = 0; c < NUM_CH; c++)
                        duty_next[c] = mag[c][DUTY_W-1:0];
                end
            end
            KIND_PWM_TICK:
            begin
                if (locked_reg)
                begin
                    pwm_next     = '0;
                    standby_next = 1'b0;
                end
                else
                begin
                    standby_next = 1'b1;
                    pwm_next     = pwm_cmp;
                    phase_next   = (phase_reg >= PH_LAST) ? '0 : phase_reg + 1'b1;
                end
            end
            KIND_COAST:
            begin
                first_next  = '0;
                second_next = '0;
                pwm_next    = '0;
                for (int c = 0; c < NUM_CH; c++)
                    duty_next[c] = '0;
            end
            KIND_BRAKE, KIND_LOCK:
            begin
                if (!locked_reg)
                begin
                    standby_next = 1'b1;
                    pwm_next     = ALL_CH;
                    first_next   = ALL_CH;
                    second_next  = ALL_CH;
                    for (int c = 0; c < NUM_CH; c++)
                        duty_next[c] = max_speed;
                end
                if (word.kind == KIND_LOCK)
                begin
                    pwm_next     = '0;
                    standby_next = 1'b0;
                    locked_next  = 1'b1;
                end
            end
            KIND_UNLOCK:
            begin
                standby_next = 1'b1;
                pwm_next     = ALL_CH;
                locked_next  = 1'b0;
            end
            default:
            begin
                locked_next = locked_reg;
            end
        endcase
    end

    // Hold state; it doubles as the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            locked_reg  <= 1'b1;
            first_reg   <= '0;
            second_reg  <= '0;
            pwm_reg     <= '0;
            standby_reg <= 1'b0;
            phase_reg   <= '0;
            for (int c = 0; c < NUM_CH; c++)
                duty_reg[c] <= '0;
        end
        else
        begin
            if (take)
                out_vld_reg <= vld;
            if (apply)
            begin
                locked_reg  <= locked_next;
                first_reg   <= first_next;
                second_reg  <= second_next;
                pwm_reg     <= pwm_next;
                standby_reg <= standby_next;
                phase_reg   <= phase_next;
                for (int c = 0; c < NUM_CH; c++)
                    duty_reg[c] <= duty_next[c];
            end
        end
    end

    assign pins.valid         = out_vld_reg;
    assign pins.first_inputs  = first_reg;
    assign pins.second_inputs = second_reg;
    assign pins.pwm_pins      = pwm_reg;
    assign pins.standby       = standby_reg;
    assign pins.is_locked     = locked_reg;

    // Locked driver keeps standby low and all PWM pins off
    a_locked_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |-> (!standby_reg && pwm_reg == '0))
        else $error("locked driver has standby or PWM active");

    // Phase stays inside the PWM period
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_LAST)
        else $error("PWM phase out of range");

    // Phase does not move while locked
    a_phase_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |=> $stable(phase_reg))
        else $error("PWM phase advanced while locked");

    // Both bridge inputs high only as a full brake
    a_brake_only: assert property (@(posedge clk) disable iff (!rst_n)
        ((first_reg & second_reg) != '0) |-> (first_reg == ALL_CH && second_reg == ALL_CH))
        else $error("partial brake pattern on bridge inputs");

    // State changes only when a command word is applied
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !apply |=> ($stable(locked_reg) && $stable(pwm_reg) && $stable(standby_reg)))
        else $error("driver state changed without a command");

endmodule
